/* hdl/igrf_pkg.sv */
// Shared types and codes for the idle-gap response framer.
package igrf_pkg;

  // Request codes carried by in_req_type
  localparam logic [1:0] REQ_BYTE     = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_TX_START = 2'd2;

  // Configuration register indexes
  localparam logic CFG_IDLE_LIMIT  = 1'b0;
  localparam logic CFG_STALE_LIMIT = 1'b1;

  // Frame cause codes
  localparam logic CAUSE_IDLE = 1'b0;
  localparam logic CAUSE_FULL = 1'b1;

  localparam int unsigned LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST  = 16'd10;
  localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST = 16'd100;
  localparam logic [LIMIT_W-1:0] SILENCE_MAX     = 16'hFFFF;

  // Datapath status seen by the controller
  typedef struct packed {
    logic start_emit;  // the offered transaction opens a frame
    logic last_idx;    // read pointer sits on the final stored byte
    logic out_free;    // output register can take a byte this cycle
  } igrf_status_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic take_item;   // input transaction accepted this cycle
    logic read_en;     // load the next frame byte into the output register
    logic finish;      // final frame byte loaded, close the frame
  } igrf_cmd_t;

endpackage

/* hdl/igrf_ctrl.sv */
// Controller state machine: accepts transactions and sequences frame drains.
module igrf_ctrl
  import igrf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  igrf_status_t status,
  output igrf_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } igrf_state_t;

  igrf_state_t state_r, state_nxt;

  // Decode commands from the current state
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd.take_item = in_valid && (state_r == ST_IDLE);
    cmd.read_en   = (state_r == ST_DRAIN) && status.out_free;
    cmd.finish    = cmd.read_en && status.last_idx;
  end

  // Advance the state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take_item && status.start_emit) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cmd.finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A frame start always leads into a drain
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_item && status.start_emit) |=> (state_r == ST_DRAIN))
    else $error("frame start did not enter drain");

  // No byte is read outside a drain
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_en |-> !in_ready)
    else $error("frame read while accepting input");

  // Closing a frame returns to accepting input
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready)
    else $error("input not reopened after frame");

endmodule

/* hdl/igrf_dp.sv */
// Datapath: limits, frame store, fill and silence counters, output register.
module igrf_dp
  import igrf_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_rx_byte,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_of_frame,
  output logic               out_frame_cause,
  input  igrf_cmd_t          cmd,
  output igrf_status_t       status
);

  localparam int unsigned IDX_W  = $clog2(BUFFER_DEPTH);
  localparam int unsigned FILL_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_DEPTH);
  localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

  logic [LIMIT_W-1:0] idle_limit_r, stale_limit_r;
  logic [FILL_W-1:0]  fill_r, fill_nxt, fill_eff;
  logic [LIMIT_W-1:0] sil_r, sil_nxt, sil_inc;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               cause_r;
  logic [7:0]         pend_r;
  logic               stale_hit, full_eff;

  logic [7:0]         mem [BUFFER_DEPTH];
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [7:0]         wr_data;

  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_last_r;
  logic               out_cause_r;

  // Write the limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r  <= IDLE_LIMIT_RST;
      stale_limit_r <= STALE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_LIMIT:  idle_limit_r  <= cfg_wdata;
        CFG_STALE_LIMIT: stale_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decide how the offered transaction treats the buffer
  always_comb begin
    stale_hit = (fill_r != '0) && (sil_r >= stale_limit_r);
    fill_eff  = stale_hit ? '0 : fill_r;
    full_eff  = (fill_eff == FILL_FULL);
    sil_inc   = (sil_r == SILENCE_MAX) ? sil_r : sil_r + LIMIT_W'(1);
    unique case (in_req_type)
      REQ_BYTE: status.start_emit = full_eff;
      REQ_TICK: status.start_emit = (fill_r != '0) && (sil_inc >= idle_limit_r);
      default:  status.start_emit = 1'b0;
    endcase
    status.last_idx = (FILL_W'(rd_idx_r) == (fill_r - FILL_ONE));
    status.out_free = !out_valid_r || out_ready;
  end

  // Update fill, silence and the store write port
  always_comb begin
    fill_nxt = fill_r;
    sil_nxt  = sil_r;
    wr_en    = 1'b0;
    wr_addr  = fill_eff[IDX_W-1:0];
    wr_data  = in_rx_byte;
    if (cmd.take_item) begin
      unique case (in_req_type)
        REQ_BYTE: begin
          sil_nxt = '0;
          if (!full_eff) begin
            wr_en    = 1'b1;
            fill_nxt = fill_eff + FILL_ONE;
          end
        end
        REQ_TICK:     sil_nxt  = sil_inc;
        REQ_TX_START: fill_nxt = '0;
        default: ;
      endcase
    end
    // Close the frame; a full-buffer frame then keeps the held byte
    if (cmd.finish) begin
      if (cause_r == CAUSE_FULL) begin
        wr_en    = 1'b1;
        wr_addr  = '0;
        wr_data  = pend_r;
        fill_nxt = FILL_ONE;
      end else begin
        fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      sil_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      sil_r  <= sil_nxt;
      if (cmd.take_item && status.start_emit) begin
        rd_idx_r <= '0;
      end else if (cmd.read_en) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  // Hold the frame cause and the byte that waits behind a full frame
  always_ff @(posedge clk) begin
    if (cmd.take_item && status.start_emit) begin
      cause_r <= (in_req_type == REQ_BYTE) ? CAUSE_FULL : CAUSE_IDLE;
      pend_r  <= in_rx_byte;
    end
  end

  // Frame store: one write port, registered read into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read_en) begin
      out_byte_r  <= mem[rd_idx_r];
      out_last_r  <= status.last_idx;
      out_cause_r <= cause_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.read_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_frame = out_last_r;
  assign out_frame_cause   = out_cause_r;

  // Fill count never passes the buffer depth
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count above buffer depth");

  // Reads stay inside the stored bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_en |-> (FILL_W'(rd_idx_r) < fill_r))
    else $error("frame read past fill count");

  // A full-buffer frame leaves exactly the held byte behind
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (cause_r == CAUSE_FULL)) |=> (fill_r == FILL_ONE))
    else $error("held byte not kept after full frame");

endmodule

/* hdl/idle_gap_response_framer.sv */
// in_ready is high while idle; a transaction that opens no frame leaves it high.
// A frame of n bytes drains from the store at one byte per cycle unless out_ready stalls it,
// paced by the store's registered read port; the controller enters its drain state after
// the opening transaction. Input stalls during the drain; output backpressure stretches it.
// Reset (rst_n low, synchronous) empties the buffer, zeroes the silence count and sets
// idle_limit to 10 and stale_limit to 100; store contents are left as they are.
module idle_gap_response_framer
  import igrf_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_of_frame,
  output logic               out_frame_cause,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  igrf_status_t status;
  igrf_cmd_t    cmd;

  igrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  igrf_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_frame_cause   (out_frame_cause),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

/* bench/tb.sv */
// Self-checking bench for the idle-gap response framer: random traffic, shadow predictor, scoreboard.
module tb;
  import igrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = 64;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } serial_event_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       cause;
  } frame_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = REQ_TICK;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               out_last_of_frame;
  logic               out_frame_cause;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_IDLE_LIMIT;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  serial_event_t pending_events[$];
  frame_byte_t   frame_expect[$];
  logic          in_taken = 1'b0;
  logic          calm = 1'b0;
  int            errors = 0;
  int            quiet_cycles = 0;

  // Shadow copy of the framer state and registers
  logic [7:0]         shadow_store [0:STORE_DEPTH-1];
  logic [6:0]         shadow_fill;
  logic [15:0]        shadow_silence;
  logic [LIMIT_W-1:0] shadow_idle_limit;
  logic [LIMIT_W-1:0] shadow_stale_limit;

  idle_gap_response_framer #(.BUFFER_DEPTH(STORE_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_frame(out_last_of_frame),
    .out_frame_cause  (out_frame_cause),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Flush the stored bytes as one frame, oldest first
  task automatic flush_frame(input logic cause);
    frame_byte_t fb;
    for (int k = 0; k < shadow_fill; k++) begin
      fb.data  = shadow_store[k];
      fb.last  = (k == shadow_fill - 1);
      fb.cause = cause;
      frame_expect.push_back(fb);
    end
    shadow_fill = '0;
  endtask

  // Advance the shadow framer by one accepted transaction
  task automatic predict_frame_bytes(input logic [1:0] kind, input logic [7:0] value);
    case (kind)
      REQ_BYTE: begin
        if (shadow_fill != 0 && shadow_silence >= shadow_stale_limit) shadow_fill = '0;
        if (shadow_fill >= STORE_DEPTH) flush_frame(CAUSE_FULL);
        shadow_store[shadow_fill[5:0]] = value;
        shadow_fill = shadow_fill + 7'd1;
        shadow_silence = '0;
      end
      REQ_TICK: begin
        if (shadow_silence != SILENCE_MAX) shadow_silence = shadow_silence + 16'd1;
        if (shadow_fill != 0 && shadow_silence >= shadow_idle_limit) flush_frame(CAUSE_IDLE);
      end
      REQ_TX_START: shadow_fill = '0;
      default: ;
    endcase
  endtask

  // Drive the input channel and the result-side backpressure
  always @(negedge clk) begin : drive
    serial_event_t next_event;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        next_event = pending_events.pop_front();
        in_valid    <= 1'b1;
        in_req_type <= next_event.kind;
        in_rx_byte  <= next_event.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 20);
  end

  // Sample both channels, predict, check, and watch for a hang
  always @(posedge clk) begin : observe
    frame_byte_t want;
    in_taken <= in_valid && in_ready;
    if (!rst_n) begin
      shadow_fill        = '0;
      shadow_silence     = '0;
      shadow_idle_limit  = IDLE_LIMIT_RST;
      shadow_stale_limit = STALE_LIMIT_RST;
      quiet_cycles       = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDLE_LIMIT) shadow_idle_limit = cfg_wdata;
        else shadow_stale_limit = cfg_wdata;
      end
      if (in_valid && in_ready) predict_frame_bytes(in_req_type, in_rx_byte);
      if (out_valid && out_ready) begin
        if (frame_expect.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected frame byte %02h last=%0b cause=%0b", $realtime,
                     out_byte, out_last_of_frame, out_frame_cause);
        end else begin
          want = frame_expect.pop_front();
          if (out_byte !== want.data || out_last_of_frame !== want.last ||
              out_frame_cause !== want.cause) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: frame byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       $realtime, want.data, want.last, want.cause,
                       out_byte, out_last_of_frame, out_frame_cause);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic add_event(input logic [1:0] kind, input logic [7:0] value);
    serial_event_t ev;
    ev.kind  = kind;
    ev.value = value;
    pending_events.push_back(ev);
  endtask

  // Write one register through the config port while the framer is idle
  task automatic write_reg(input logic index, input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every transaction is taken and every frame byte has come out
  task automatic wait_drained();
    while (pending_events.size() != 0 || in_valid || frame_expect.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly byte bursts closed by ticks, with some stray requests mixed in
  task automatic queue_traffic(input int target);
    int added;
    int burst;
    int ticks;
    logic [1:0] kind;
    added = 0;
    while (added < target) begin
      if ($urandom_range(99) < 75) begin
        burst = ($urandom_range(9) == 0) ? $urandom_range(70, 60) : $urandom_range(6, 1);
        for (int k = 0; k < burst; k++) add_event(REQ_BYTE, 8'($urandom_range(255)));
        ticks = $urandom_range(14);
        for (int k = 0; k < ticks; k++) add_event(REQ_TICK, 8'($urandom_range(255)));
        added += burst + ticks;
        if ($urandom_range(4) == 0) begin
          add_event(REQ_TX_START, 8'($urandom_range(255)));
          added++;
        end
      end else begin
        kind = 2'($urandom_range(3));
        add_event(kind, 8'($urandom_range(255)));
        if (kind != REQ_UNUSED) added++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: short limits so idle flush and stale discard both show up
    write_reg(CFG_IDLE_LIMIT, 16'd3);
    write_reg(CFG_STALE_LIMIT, 16'd2);
    add_event(REQ_UNUSED, 8'hFF);
    add_event(REQ_TICK, 8'h00);
    add_event(REQ_BYTE, 8'h00);
    add_event(REQ_BYTE, 8'hFF);
    repeat (3) add_event(REQ_TICK, 8'hFF);
    add_event(REQ_BYTE, 8'h5A);
    add_event(REQ_TX_START, 8'hA5);
    repeat (3) add_event(REQ_TICK, 8'h00);
    add_event(REQ_BYTE, 8'h11);
    repeat (2) add_event(REQ_TICK, 8'h00);
    add_event(REQ_BYTE, 8'h22);
    repeat (3) add_event(REQ_TICK, 8'h00);
    wait_drained();

    // Smallest nonzero limits
    write_reg(CFG_IDLE_LIMIT, 16'd1);
    write_reg(CFG_STALE_LIMIT, 16'd1);
    queue_traffic(20);
    wait_drained();

    // Largest limits: no idle flush, then fill the store past its depth
    write_reg(CFG_IDLE_LIMIT, 16'hFFFF);
    write_reg(CFG_STALE_LIMIT, 16'hFFFF);
    add_event(REQ_BYTE, 8'h3C);
    add_event(REQ_BYTE, 8'hC3);
    repeat (5) add_event(REQ_TICK, 8'($urandom_range(255)));
    wait_drained();
    add_event(REQ_TX_START, 8'h00);
    repeat (66) add_event(REQ_BYTE, 8'($urandom_range(255)));
    add_event(REQ_TX_START, 8'h00);
    wait_drained();

    // Zero limits: every byte drops the partial frame, every tick flushes a non-empty buffer
    write_reg(CFG_IDLE_LIMIT, 16'd0);
    write_reg(CFG_STALE_LIMIT, 16'd0);
    queue_traffic(20);
    wait_drained();

    // Mid-range limits with no idling on either side
    calm = 1'b1;
    write_reg(CFG_IDLE_LIMIT, LIMIT_W'($urandom_range(12, 2)));
    write_reg(CFG_STALE_LIMIT, LIMIT_W'($urandom_range(15, 1)));
    queue_traffic(20);
    wait_drained();
    calm = 1'b0;

    // Back to the power-up limits
    write_reg(CFG_IDLE_LIMIT, IDLE_LIMIT_RST);
    write_reg(CFG_STALE_LIMIT, STALE_LIMIT_RST);
    queue_traffic(20);
    wait_drained();

    repeat (20) @(posedge clk);
    if (frame_expect.size() != 0) begin
      errors++;
      $display("%0d frame bytes never came out", frame_expect.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
